@@ src/plu_pkg.sv @@
// ----------------------------------------------------------------------------
// plu_pkg: shared types and arithmetic for the pixel lift and undistort block
// Payload structs, register indexes, and Q.24 fixed-point helpers.
// ----------------------------------------------------------------------------
package plu_pkg;

  localparam int ITERATIONS = 8;
  localparam int IterStages = 7;
  localparam int LiftStages = 2;
  localparam int Latency    = LiftStages + IterStages * ITERATIONS;

  typedef struct packed {
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
  } pix_req_t;

  typedef struct packed {
    logic signed [31:0] ray_x;
    logic signed [31:0] ray_y;
  } ray_rsp_t;

  typedef struct packed {
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
  } coef_t;

  typedef enum logic [2:0] {
    RegInvFocalX = 3'd0,
    RegOffsetX   = 3'd1,
    RegInvFocalY = 3'd2,
    RegOffsetY   = 3'd3,
    RegRadialK1  = 3'd4,
    RegRadialK2  = 3'd5,
    RegTangP1    = 3'd6,
    RegTangP2    = 3'd7
  } reg_idx_e;

  function automatic logic signed [31:0] sat_q(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Q.24 product, rounded half up, saturated.
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    logic signed [63:0] s;
    p = 64'(a) * 64'(b);
    s = (p + 64'sd8388608) >>> 24;
    return sat_q(s[39:0]);
  endfunction

endpackage

@@ src/pixel_lift_undistort.sv @@
// ----------------------------------------------------------------------------
// pixel_lift_undistort: pixel to undistorted normalized ray
// Lifts a Q12.4 pixel through the inverse intrinsics and removes radial and
// tangential lens distortion by a fixed number of unrolled passes.
// ----------------------------------------------------------------------------
// A new pixel is taken in every cycle; busy_o never rises. Each transaction
// yields one ray on rsp_o, strobed by ray_valid_o, after the 2 lift stages
// and the 7 stages of each of the 8 passes; the depth is set by the chain
// of dependent multiplications inside each pass. The receiver cannot stall
// the output. The user must write registers only while the pipeline is
// empty; the block itself does not enforce this.
module pixel_lift_undistort (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  plu_pkg::pix_req_t  req_i,
  output logic               ray_valid_o,
  output plu_pkg::ray_rsp_t  rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import plu_pkg::*;

  logic [24:0]        inv_fx_q, inv_fy_q;
  logic signed [28:0] off_x_q, off_y_q, k1_q, k2_q, p1_q, p2_q;
  reg_idx_e           widx;
  logic               wr_en;
  coef_t              coef;

  assign pready = 1'b1;
  assign busy_o = 1'b0;
  assign wr_en  = psel && penable && pwrite && pready;
  assign widx   = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_fx_q <= 25'd16777216;
      inv_fy_q <= 25'd16777216;
      off_x_q  <= '0;
      off_y_q  <= '0;
      k1_q     <= '0;
      k2_q     <= '0;
      p1_q     <= '0;
      p2_q     <= '0;
    end else if (wr_en) begin
      unique case (widx)
        RegInvFocalX: inv_fx_q <= pwdata[24:0];
        RegOffsetX:   off_x_q  <= pwdata[28:0];
        RegInvFocalY: inv_fy_q <= pwdata[24:0];
        RegOffsetY:   off_y_q  <= pwdata[28:0];
        RegRadialK1:  k1_q     <= pwdata[28:0];
        RegRadialK2:  k2_q     <= pwdata[28:0];
        RegTangP1:    p1_q     <= pwdata[28:0];
        RegTangP2:    p2_q     <= pwdata[28:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      RegInvFocalX: prdata = {7'd0, inv_fx_q};
      RegOffsetX:   prdata = 32'(off_x_q);
      RegInvFocalY: prdata = {7'd0, inv_fy_q};
      RegOffsetY:   prdata = 32'(off_y_q);
      RegRadialK1:  prdata = 32'(k1_q);
      RegRadialK2:  prdata = 32'(k2_q);
      RegTangP1:    prdata = 32'(p1_q);
      RegTangP2:    prdata = 32'(p2_q);
      default:      prdata = '0;
    endcase
  end

  assign coef = '{k1: 32'(k1_q), k2: 32'(k2_q), p1: 32'(p1_q), p2: 32'(p2_q)};

  // Lift through the inverse intrinsics.
  logic               acc;
  logic [1:0]         lv_q;
  logic [40:0]        prod_x_q, prod_y_q;
  logic [41:0]        rnd_x, rnd_y;
  logic signed [31:0] mx_q, my_q;

  assign acc   = start_i && !busy_o;
  assign rnd_x = 42'(prod_x_q) + 42'd8;
  assign rnd_y = 42'(prod_y_q) + 42'd8;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_q <= '0;
    end else begin
      lv_q <= {lv_q[0], acc};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_x_q <= 41'(req_i.pixel_x) * 41'(inv_fx_q);
    prod_y_q <= 41'(req_i.pixel_y) * 41'(inv_fy_q);
    mx_q <= sat_q($signed({2'b00, rnd_x[41:4]}) + 40'(off_x_q));
    my_q <= sat_q($signed({2'b00, rnd_y[41:4]}) + 40'(off_y_q));
  end

  logic               it_vld [ITERATIONS+1];
  logic signed [31:0] it_mx  [ITERATIONS+1];
  logic signed [31:0] it_my  [ITERATIONS+1];
  logic signed [31:0] it_ux  [ITERATIONS+1];
  logic signed [31:0] it_uy  [ITERATIONS+1];

  assign it_vld[0] = lv_q[1];
  assign it_mx[0]  = mx_q;
  assign it_my[0]  = my_q;
  assign it_ux[0]  = mx_q;
  assign it_uy[0]  = my_q;

  // The measured point travels beside each pass; its delay matches the pass.
  for (genvar g = 0; g < ITERATIONS; g++) begin : g_pass
    logic signed [31:0] mxd_q [IterStages];
    logic signed [31:0] myd_q [IterStages];

    always_ff @(posedge clk_i) begin
      mxd_q[0] <= it_mx[g];
      myd_q[0] <= it_my[g];
      for (int s = 1; s < IterStages; s++) begin
        mxd_q[s] <= mxd_q[s-1];
        myd_q[s] <= myd_q[s-1];
      end
    end

    plu_iter u_iter (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .coef_i (coef),
      .vld_i  (it_vld[g]),
      .mx_i   (it_mx[g]),
      .my_i   (it_my[g]),
      .ux_i   (it_ux[g]),
      .uy_i   (it_uy[g]),
      .vld_o  (it_vld[g+1]),
      .ux_o   (it_ux[g+1]),
      .uy_o   (it_uy[g+1])
    );

    assign it_mx[g+1] = mxd_q[IterStages-1];
    assign it_my[g+1] = myd_q[IterStages-1];
  end

  assign ray_valid_o = it_vld[ITERATIONS];
  assign rsp_o       = '{ray_x: it_ux[ITERATIONS], ray_y: it_uy[ITERATIONS]};

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##Latency (ray_valid_o == $past(acc, Latency)))
    else $error("result strobe does not match an accepted transaction");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised although the pipeline never stalls");

  a_lift_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##2 (lv_q[1] == $past(acc, 2)))
    else $error("lift stage valid lost or invented");

endmodule

@@ src/plu_iter.sv @@
// ----------------------------------------------------------------------------
// plu_iter: one undistortion pass
// Evaluates the distortion at the current estimate and forms u = d - D(u)
// over seven register stages.
// ----------------------------------------------------------------------------
module plu_iter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  plu_pkg::coef_t      coef_i,
  input  logic                vld_i,
  input  logic signed [31:0]  mx_i,
  input  logic signed [31:0]  my_i,
  input  logic signed [31:0]  ux_i,
  input  logic signed [31:0]  uy_i,
  output logic                vld_o,
  output logic signed [31:0]  ux_o,
  output logic signed [31:0]  uy_o
);
  import plu_pkg::*;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] mx;
    logic signed [31:0] my;
  } ctx_t;

  ctx_t ctx_in;
  ctx_t c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
  logic [6:0] vld_q;

  logic signed [31:0] x2_1_q, y2_1_q, xy_1_q;
  logic signed [31:0] r2_2_q, tx_2_q, ty_2_q, xy_2_q;
  logic signed [31:0] r4_3_q, a_3_q, pa_3_q, pb_3_q, tx_3_q, ty_3_q;
  logic signed [31:0] b_4_q, a_4_q, pa_4_q, pb_4_q, tx_4_q, ty_4_q;
  logic signed [31:0] rad_5_q, pa_5_q, pb_5_q, tx_5_q, ty_5_q;
  logic signed [31:0] xr_6_q, yr_6_q, pa_6_q, pb_6_q, tx_6_q, ty_6_q;
  logic signed [31:0] ux_q, uy_q;

  logic signed [31:0] r2_d, tx_d, ty_d, dx_d, dy_d;

  assign ctx_in = '{x: ux_i, y: uy_i, mx: mx_i, my: my_i};

  always_comb begin
    r2_d = sat_q(40'(x2_1_q) + 40'(y2_1_q));
    tx_d = sat_q(40'(r2_d) + 40'(x2_1_q) + 40'(x2_1_q));
    ty_d = sat_q(40'(r2_d) + 40'(y2_1_q) + 40'(y2_1_q));
    dx_d = sat_q(40'(xr_6_q) + 40'(pa_6_q) + 40'(pa_6_q) + 40'(tx_6_q));
    dy_d = sat_q(40'(yr_6_q) + 40'(pb_6_q) + 40'(pb_6_q) + 40'(ty_6_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[5:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    // Products of the current estimate.
    c1_q   <= ctx_in;
    x2_1_q <= qmul(ux_i, ux_i);
    y2_1_q <= qmul(uy_i, uy_i);
    xy_1_q <= qmul(ux_i, uy_i);
    // Radius and tangential sums.
    c2_q   <= c1_q;
    r2_2_q <= r2_d;
    tx_2_q <= tx_d;
    ty_2_q <= ty_d;
    xy_2_q <= xy_1_q;
    // Coefficient products.
    c3_q   <= c2_q;
    r4_3_q <= qmul(r2_2_q, r2_2_q);
    a_3_q  <= qmul(coef_i.k1, r2_2_q);
    pa_3_q <= qmul(coef_i.p1, xy_2_q);
    pb_3_q <= qmul(coef_i.p2, xy_2_q);
    tx_3_q <= qmul(coef_i.p2, tx_2_q);
    ty_3_q <= qmul(coef_i.p1, ty_2_q);
    // Fourth-order radial term.
    c4_q   <= c3_q;
    b_4_q  <= qmul(coef_i.k2, r4_3_q);
    a_4_q  <= a_3_q;
    pa_4_q <= pa_3_q;
    pb_4_q <= pb_3_q;
    tx_4_q <= tx_3_q;
    ty_4_q <= ty_3_q;
    // Radial factor.
    c5_q    <= c4_q;
    rad_5_q <= sat_q(40'(a_4_q) + 40'(b_4_q));
    pa_5_q  <= pa_4_q;
    pb_5_q  <= pb_4_q;
    tx_5_q  <= tx_4_q;
    ty_5_q  <= ty_4_q;
    // Radial displacement.
    c6_q   <= c5_q;
    xr_6_q <= qmul(c5_q.x, rad_5_q);
    yr_6_q <= qmul(c5_q.y, rad_5_q);
    pa_6_q <= pa_5_q;
    pb_6_q <= pb_5_q;
    tx_6_q <= tx_5_q;
    ty_6_q <= ty_5_q;
    // New estimate.
    ux_q <= sat_q(40'(c6_q.mx) - 40'(dx_d));
    uy_q <= sat_q(40'(c6_q.my) - 40'(dy_d));
  end

  assign vld_o = vld_q[6];
  assign ux_o  = ux_q;
  assign uy_o  = uy_q;

  a_iter_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##7 (vld_o == $past(vld_i, 7)))
    else $error("pass output valid does not follow its input by seven cycles");

endmodule
